// File: src/team_queue_core_assert.svh
// Assertion macros for the team queue checker.
// Expects i_clk and i_rst_n in the scope that uses them.
`ifndef TEAM_QUEUE_CORE_ASSERT_SVH
`define TEAM_QUEUE_CORE_ASSERT_SVH

// Check a property on every clock outside reset.
`define TQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define TQ_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

// File: src/tq_pkg.sv
// Team queue package: field widths, request and status codes, FSM states.
// No dependencies.
package tq_pkg;

    localparam int unsigned ID_COUNT_DEF    = 1024;
    localparam int unsigned MAX_TEAMS_DEF   = 128;
    localparam int unsigned ENTRY_COUNT_DEF = 256;

    localparam int REQ_W    = 2;
    localparam int ID_W     = 10;
    localparam int TIDX_W   = 7;
    localparam int CFG_W    = 8;
    localparam int STATUS_W = 3;

    localparam logic [REQ_W-1:0] REQ_ASSIGN  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ENQUEUE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DEQUEUE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

    localparam logic [STATUS_W-1:0] ST_ASSIGNED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ENQUEUED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_SERVED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd4;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_ENQ_CHECK,
        S_ENQ_LINK,
        S_DEQ_TEAM,
        S_DEQ_ENTRY,
        S_DEQ_POP,
        S_DONE
    } t_state;

endpackage

// File: src/tq_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module tq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/team_queue_core.sv
// Channel | valid      | stall       | payload
// in      | i_in_valid | o_in_stall  | i_req_type, i_member_id, i_team_index
// out     | o_out_valid| i_out_stall | o_serve_id, o_status
// cfg     | i_cfg_we   | -           | i_cfg_wdata
// One item at a time under one sequencer; each memory step is a registered
// read. Assign, unknown and empty-dequeue items pass EXEC and DONE, a
// rejected enqueue also ENQ_CHECK, an enqueue also ENQ_LINK, a dequeue
// DEQ_TEAM, DEQ_ENTRY and DEQ_POP (order head, team head, entry link in turn).
// After reset a clearing pass over all ID_COUNT entries empties the member table;
// input stalls meanwhile, configuration writes are taken.
// A stalled result holds in the output register; the next item may run
// and waits in S_DONE until the register frees.
// Depends on tq_pkg and tq_ram.
module team_queue_core
    import tq_pkg::*;
#(
    parameter int unsigned ID_COUNT    = ID_COUNT_DEF,
    parameter int unsigned MAX_TEAMS   = MAX_TEAMS_DEF,
    parameter int unsigned ENTRY_COUNT = ENTRY_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [REQ_W-1:0]    i_req_type,
    input  logic [ID_W-1:0]     i_member_id,
    input  logic [TIDX_W-1:0]   i_team_index,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [ID_W-1:0]     o_serve_id,
    output logic [STATUS_W-1:0] o_status,
    input  logic                i_cfg_we,
    input  logic [CFG_W-1:0]    i_cfg_wdata
);

    localparam int IW = $clog2(ID_COUNT);
    localparam int TW = $clog2(MAX_TEAMS);
    localparam int EW = $clog2(ENTRY_COUNT);
    localparam int SW = ((TW + 1 > CFG_W) ? TW + 1 : CFG_W) + 1;

    t_state r_state, n_state;
    logic [REQ_W-1:0]       r_req, n_req;
    logic [ID_W-1:0]        r_id, n_id;
    logic [TIDX_W-1:0]      r_tidx, n_tidx;
    logic [CFG_W-1:0]       r_team_count;
    logic [TW:0]            r_fresh, n_fresh;
    logic [EW:0]            r_free_level, n_free_level;
    logic [ENTRY_COUNT-1:0] r_free_wr, n_free_wr;
    logic [MAX_TEAMS-1:0]   r_waiting, n_waiting;
    logic [TW-1:0]          r_rp, n_rp, r_wp, n_wp;
    logic [TW:0]            r_olevel, n_olevel;
    logic [IW-1:0]          r_clr, n_clr;
    logic [TW-1:0]          r_team, n_team;
    logic [EW-1:0]          r_entry, n_entry;
    logic [EW-1:0]          r_tail, n_tail;
    logic [ID_W-1:0]        r_res_id, n_res_id;
    logic [STATUS_W-1:0]    r_res_status, n_res_status;
    logic                   r_out_valid, n_out_valid;
    logic [ID_W-1:0]        r_out_id, n_out_id;
    logic [STATUS_W-1:0]    r_out_status, n_out_status;

    logic          mt_we;
    logic [IW-1:0] mt_waddr, mt_raddr;
    logic [TW:0]   mt_wdata, mt_rdata;
    logic          hd_we, tl_we;
    logic [TW-1:0] hd_waddr, hd_raddr, tl_waddr, tl_raddr;
    logic [EW-1:0] hd_wdata, hd_rdata, tl_wdata, tl_rdata;
    logic          em_we, el_we, fr_we, of_we;
    logic [EW-1:0] em_waddr, em_raddr, el_waddr, el_raddr, el_wdata, el_rdata;
    logic [ID_W-1:0] em_wdata, em_rdata;
    logic [EW-1:0] fr_waddr, fr_raddr, fr_wdata, fr_rdata;
    logic [TW-1:0] of_waddr, of_raddr, of_wdata, of_rdata;

    logic          id_ok;
    logic [SW-1:0] team_wide;
    logic [TW-1:0] team_n;
    logic          team_ok, waiting;
    logic [EW-1:0] top_idx, new_entry;

    function automatic logic [TW-1:0] ptr_next(input logic [TW-1:0] p);
        ptr_next = (p == TW'(MAX_TEAMS - 1)) ? '0 : p + 1'b1;
    endfunction

    tq_ram #(.WIDTH(TW + 1), .DEPTH(ID_COUNT)) u_member (
        .i_clk, .i_we(mt_we), .i_waddr(mt_waddr), .i_wdata(mt_wdata),
        .i_raddr(mt_raddr), .o_rdata(mt_rdata)
    );
    tq_ram #(.WIDTH(EW), .DEPTH(MAX_TEAMS)) u_head (
        .i_clk, .i_we(hd_we), .i_waddr(hd_waddr), .i_wdata(hd_wdata),
        .i_raddr(hd_raddr), .o_rdata(hd_rdata)
    );
    tq_ram #(.WIDTH(EW), .DEPTH(MAX_TEAMS)) u_tail (
        .i_clk, .i_we(tl_we), .i_waddr(tl_waddr), .i_wdata(tl_wdata),
        .i_raddr(tl_raddr), .o_rdata(tl_rdata)
    );
    tq_ram #(.WIDTH(ID_W), .DEPTH(ENTRY_COUNT)) u_emember (
        .i_clk, .i_we(em_we), .i_waddr(em_waddr), .i_wdata(em_wdata),
        .i_raddr(em_raddr), .o_rdata(em_rdata)
    );
    tq_ram #(.WIDTH(EW), .DEPTH(ENTRY_COUNT)) u_elink (
        .i_clk, .i_we(el_we), .i_waddr(el_waddr), .i_wdata(el_wdata),
        .i_raddr(el_raddr), .o_rdata(el_rdata)
    );
    tq_ram #(.WIDTH(EW), .DEPTH(ENTRY_COUNT)) u_free (
        .i_clk, .i_we(fr_we), .i_waddr(fr_waddr), .i_wdata(fr_wdata),
        .i_raddr(fr_raddr), .o_rdata(fr_rdata)
    );
    tq_ram #(.WIDTH(TW), .DEPTH(MAX_TEAMS)) u_order (
        .i_clk, .i_we(of_we), .i_waddr(of_waddr), .i_wdata(of_wdata),
        .i_raddr(of_raddr), .o_rdata(of_rdata)
    );

    assign id_ok     = 32'(r_id) < ID_COUNT;
    assign team_wide = mt_rdata[TW] ? SW'(mt_rdata[TW-1:0])
                                    : SW'(r_team_count) + SW'(r_fresh);
    assign team_n    = TW'(team_wide);
    assign team_ok   = team_wide < SW'(MAX_TEAMS);
    assign waiting   = team_ok ? r_waiting[team_n] : 1'b0;
    assign top_idx   = EW'(r_free_level - 1'b1);
    assign new_entry = r_free_wr[top_idx] ? fr_rdata : top_idx;

    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_id         = r_id;
        n_tidx       = r_tidx;
        n_fresh      = r_fresh;
        n_free_level = r_free_level;
        n_free_wr    = r_free_wr;
        n_waiting    = r_waiting;
        n_rp         = r_rp;
        n_wp         = r_wp;
        n_olevel     = r_olevel;
        n_clr        = r_clr;
        n_team       = r_team;
        n_entry      = r_entry;
        n_tail       = r_tail;
        n_res_id     = r_res_id;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_id     = r_out_id;
        n_out_status = r_out_status;

        mt_we = 1'b0; mt_waddr = IW'(r_id); mt_wdata = '0; mt_raddr = IW'(r_id);
        hd_we = 1'b0; hd_waddr = r_team; hd_wdata = r_entry; hd_raddr = of_rdata;
        tl_we = 1'b0; tl_waddr = r_team; tl_wdata = r_entry; tl_raddr = of_rdata;
        em_we = 1'b0; em_waddr = new_entry; em_wdata = r_id; em_raddr = hd_rdata;
        el_we = 1'b0; el_waddr = new_entry; el_wdata = '0; el_raddr = hd_rdata;
        fr_we = 1'b0; fr_waddr = EW'(r_free_level); fr_wdata = r_entry;
        fr_raddr = top_idx;
        of_we = 1'b0; of_waddr = r_wp; of_wdata = r_team; of_raddr = r_rp;

        unique case (r_state)
            S_CLEAR: begin
                mt_we    = 1'b1;
                mt_waddr = r_clr;
                n_clr    = r_clr + 1'b1;
                if (r_clr == IW'(ID_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_req_type;
                    n_id    = i_member_id;
                    n_tidx  = i_team_index;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res_id     = '0;
                n_res_status = ST_OVERFLOW;
                n_state      = S_DONE;
                case (r_req)
                    REQ_ASSIGN: begin
                        if (id_ok && CFG_W'(r_tidx) < r_team_count
                                && 32'(r_tidx) < MAX_TEAMS) begin
                            mt_we        = 1'b1;
                            mt_wdata     = {1'b1, TW'(r_tidx)};
                            n_res_status = ST_ASSIGNED;
                        end
                    end
                    REQ_ENQUEUE: begin
                        n_state = S_ENQ_CHECK;
                    end
                    REQ_DEQUEUE: begin
                        if (r_olevel == '0) begin
                            n_res_status = ST_EMPTY;
                        end else begin
                            n_state = S_DEQ_TEAM;
                        end
                    end
                    default: begin
                        n_res_status = ST_OVERFLOW;
                    end
                endcase
            end
            S_ENQ_CHECK: begin
                tl_raddr = team_n;
                if (!id_ok || !team_ok || r_free_level == '0
                        || (!waiting && 32'(r_olevel) >= MAX_TEAMS)) begin
                    n_state = S_DONE;
                end else begin
                    if (!mt_rdata[TW]) begin
                        mt_we    = 1'b1;
                        mt_wdata = {1'b1, team_n};
                        n_fresh  = r_fresh + 1'b1;
                    end
                    n_free_level = r_free_level - 1'b1;
                    em_we        = 1'b1;
                    el_we        = 1'b1;
                    n_team       = team_n;
                    n_entry      = new_entry;
                    n_state      = S_ENQ_LINK;
                end
            end
            S_ENQ_LINK: begin
                tl_we = 1'b1;
                if (r_waiting[r_team]) begin
                    el_we    = 1'b1;
                    el_waddr = tl_rdata;
                    el_wdata = r_entry;
                end else begin
                    n_waiting[r_team] = 1'b1;
                    hd_we    = 1'b1;
                    of_we    = 1'b1;
                    n_wp     = ptr_next(r_wp);
                    n_olevel = r_olevel + 1'b1;
                end
                n_res_status = ST_ENQUEUED;
                n_state      = S_DONE;
            end
            S_DEQ_TEAM: begin
                n_team  = of_rdata;
                n_state = S_DEQ_ENTRY;
            end
            S_DEQ_ENTRY: begin
                n_entry = hd_rdata;
                n_tail  = tl_rdata;
                n_state = S_DEQ_POP;
            end
            S_DEQ_POP: begin
                if (32'(r_free_level) < ENTRY_COUNT) begin
                    fr_we = 1'b1;
                    n_free_wr[EW'(r_free_level)] = 1'b1;
                    n_free_level = r_free_level + 1'b1;
                end
                if (r_entry == r_tail) begin
                    n_waiting[r_team] = 1'b0;
                    n_rp     = ptr_next(r_rp);
                    n_olevel = r_olevel - 1'b1;
                end else begin
                    hd_we    = 1'b1;
                    hd_wdata = el_rdata;
                end
                n_res_id     = em_rdata;
                n_res_status = ST_SERVED;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_id     = r_res_id;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_team_count <= '0;
            r_fresh      <= '0;
            r_free_level <= (EW + 1)'(ENTRY_COUNT);
            r_free_wr    <= '0;
            r_waiting    <= '0;
            r_rp         <= '0;
            r_wp         <= '0;
            r_olevel     <= '0;
            r_clr        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            if (i_cfg_we) begin
                r_team_count <= i_cfg_wdata;
            end
            r_fresh      <= n_fresh;
            r_free_level <= n_free_level;
            r_free_wr    <= n_free_wr;
            r_waiting    <= n_waiting;
            r_rp         <= n_rp;
            r_wp         <= n_wp;
            r_olevel     <= n_olevel;
            r_clr        <= n_clr;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_id         <= n_id;
        r_tidx       <= n_tidx;
        r_team       <= n_team;
        r_entry      <= n_entry;
        r_tail       <= n_tail;
        r_res_id     <= n_res_id;
        r_res_status <= n_res_status;
        r_out_id     <= n_out_id;
        r_out_status <= n_out_status;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_serve_id  = r_out_id;
    assign o_status    = r_out_status;

endmodule

// File: src/tq_checker.sv
// Port-level checks for team_queue_core, bound into team_queue_core.
// Depends on tq_pkg and team_queue_core_assert.svh.
`include "team_queue_core_assert.svh"

module tq_checker
    import tq_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic [ID_W-1:0]     o_serve_id,
    input logic [STATUS_W-1:0] o_status
);

    `TQ_ASSERT(a_status_code, o_out_valid |-> (o_status <= ST_OVERFLOW), "status code out of range")
    `TQ_NEVER(a_id_only_served, o_out_valid && o_status != ST_SERVED && o_serve_id != '0, "id set without a serve")
    `TQ_ASSERT(a_one_item, (i_in_valid && !o_in_stall) |=> o_in_stall, "second item taken while busy")
    `TQ_ASSERT(a_out_hold, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_serve_id) && $stable(o_status)), "stalled item changed")

endmodule

bind team_queue_core tq_checker u_tq_checker (.*);

// File: dv/tb.sv
// Testbench for team_queue_core: directed and random request streams with
// a scoreboard that predicts every result with its own team queue model.
// Depends on tq_pkg and the team_queue_core RTL.
module tb;
    import tq_pkg::*;

    class team_queue_scoreboard;
        bit [7:0]  team_count;
        bit [7:0]  member_team[1024];
        bit        member_valid[1024];
        bit        team_waiting[128];
        bit [7:0]  team_head[128];
        bit [7:0]  team_tail[128];
        bit [9:0]  entry_member[256];
        bit [7:0]  entry_link[256];
        bit [7:0]  free_entries[256];
        int        free_level;
        bit [6:0]  order_fifo[128];
        bit [6:0]  order_rd;
        bit [6:0]  order_wr;
        int        order_level;
        int        fresh_teams;
        bit [9:0]  exp_id[$];
        bit [2:0]  exp_status[$];
        int        errors;
        int        served_count;
        int        overflow_count;

        function new();
            team_count = 0;
            foreach (member_valid[i]) member_valid[i] = 0;
            foreach (team_waiting[i]) team_waiting[i] = 0;
            foreach (free_entries[i]) free_entries[i] = 8'(i);
            free_level = 256;
            order_rd = 0;
            order_wr = 0;
            order_level = 0;
            fresh_teams = 0;
            errors = 0;
            served_count = 0;
            overflow_count = 0;
        endfunction

        function bit [2:0] enqueue(bit [9:0] id);
            int team;
            bit fresh;
            bit [7:0] e;
            fresh = 0;
            if (member_valid[id]) begin
                team = member_team[id];
            end else begin
                team = team_count + fresh_teams;
                fresh = 1;
            end
            if (team >= 128 || free_level == 0) return ST_OVERFLOW;
            if (!team_waiting[team] && order_level >= 128) return ST_OVERFLOW;
            if (fresh) begin
                member_team[id] = 8'(team);
                member_valid[id] = 1;
                fresh_teams++;
            end
            free_level--;
            e = free_entries[free_level];
            entry_member[e] = id;
            entry_link[e] = 0;
            if (team_waiting[team]) begin
                entry_link[team_tail[team]] = e;
                team_tail[team] = e;
            end else begin
                team_waiting[team] = 1;
                team_head[team] = e;
                team_tail[team] = e;
                order_fifo[order_wr] = 7'(team);
                order_wr++;
                order_level++;
            end
            return ST_ENQUEUED;
        endfunction

        function void note_item(bit [1:0] req, bit [9:0] id, bit [6:0] tidx);
            bit [9:0] served;
            bit [2:0] st;
            bit [6:0] team;
            bit [7:0] e;
            served = 0;
            if (req == REQ_ASSIGN) begin
                if (tidx >= team_count) begin
                    st = ST_OVERFLOW;
                end else begin
                    member_team[id] = {1'b0, tidx};
                    member_valid[id] = 1;
                    st = ST_ASSIGNED;
                end
            end else if (req == REQ_ENQUEUE) begin
                st = enqueue(id);
            end else if (req == REQ_DEQUEUE) begin
                if (order_level == 0) begin
                    st = ST_EMPTY;
                end else begin
                    team = order_fifo[order_rd];
                    e = team_head[team];
                    served = entry_member[e];
                    if (free_level < 256) begin
                        free_entries[free_level] = e;
                        free_level++;
                    end
                    if (e == team_tail[team]) begin
                        team_waiting[team] = 0;
                        order_rd++;
                        order_level--;
                    end else begin
                        team_head[team] = entry_link[e];
                    end
                    st = ST_SERVED;
                end
            end else begin
                st = ST_OVERFLOW;
            end
            if (st == ST_SERVED) served_count++;
            if (st == ST_OVERFLOW) overflow_count++;
            exp_id = {exp_id, served};
            exp_status = {exp_status, st};
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(bit [9:0] id, bit [2:0] st);
            bit [9:0] eid;
            bit [2:0] est;
            if (exp_status.size() == 0) begin
                report_mismatch("result with nothing expected");
                return;
            end
            eid = exp_id.pop_front();
            est = exp_status.pop_front();
            if (st !== est)
                report_mismatch($sformatf("status %0d, expected %0d", st, est));
            if (id !== eid)
                report_mismatch($sformatf("result id %0d, expected %0d", id, eid));
        endtask
    endclass

    logic              clk = 0;
    logic              rst_n = 0;
    logic              in_valid = 0;
    logic              in_stall;
    logic [REQ_W-1:0]  req_type = 0;
    logic [ID_W-1:0]   member_id = 0;
    logic [TIDX_W-1:0] team_index = 0;
    logic              out_valid;
    logic              out_stall = 0;
    logic [ID_W-1:0]   serve_id;
    logic [STATUS_W-1:0] status;
    logic              cfg_we = 0;
    logic [CFG_W-1:0]  cfg_wdata = 0;

    team_queue_scoreboard sb = new();
    bit quiet_phase = 0;
    int sent = 0;

    team_queue_core u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_req_type(req_type), .i_member_id(member_id), .i_team_index(team_index),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_serve_id(serve_id), .o_status(status),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata)
    );

    always #1 clk = ~clk;

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) sb.check_result(serve_id, status);
        if (rst_n && in_valid && !in_stall) sb.note_item(req_type, member_id, team_index);
    end

    initial begin
        @(negedge clk);
        forever begin
            if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                out_stall <= 1;
                repeat ($urandom_range(1, 16)) @(negedge clk);
            end
            out_stall <= 0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
    end

    task automatic send_item(input logic [1:0] req, input logic [9:0] id,
                             input logic [6:0] tidx);
        if (!quiet_phase && $urandom_range(0, 7) == 0) begin
            in_valid <= 0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        in_valid <= 1;
        req_type <= req;
        member_id <= id;
        team_index <= tidx;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.exp_status.size() != 0) @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_team_count(input logic [7:0] value);
        drain();
        cfg_we <= 1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 0;
        sb.team_count = value;
    endtask

    task automatic random_phase(input int count, input int id_span, input int tspan);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 15)
                send_item(REQ_ASSIGN, 10'($urandom_range(0, id_span)),
                          7'($urandom_range(0, tspan)));
            else if (r < 55)
                send_item(REQ_ENQUEUE, 10'($urandom_range(0, id_span)), 7'($urandom));
            else if (r < 97)
                send_item(REQ_DEQUEUE, 10'($urandom), 7'($urandom));
            else
                send_item(REQ_UNKNOWN, 10'($urandom), 7'($urandom));
        end
    endtask

    initial begin
        repeat (7) @(negedge clk);
        rst_n <= 1;
        send_item(REQ_DEQUEUE, 10'h3ff, 7'h7f);
        send_item(REQ_ASSIGN, 5, 0);
        send_item(REQ_ENQUEUE, 10'h3ff, 0);
        send_item(REQ_ENQUEUE, 0, 0);
        send_item(REQ_UNKNOWN, 10'h2aa, 7'h55);
        write_team_count(8'd128);
        send_item(REQ_ASSIGN, 10'h3ff, 7'h7f);
        send_item(REQ_ASSIGN, 0, 0);
        send_item(REQ_ASSIGN, 1, 7'h7f);
        send_item(REQ_ENQUEUE, 1, 0);
        send_item(REQ_ENQUEUE, 10'h3ff, 0);
        send_item(REQ_ENQUEUE, 0, 0);
        send_item(REQ_ASSIGN, 0, 7'h7f);
        send_item(REQ_ENQUEUE, 0, 0);
        send_item(REQ_ENQUEUE, 2, 0);
        send_item(REQ_ENQUEUE, 10'h155, 0);
        for (int i = 0; i < 6; i++) send_item(REQ_DEQUEUE, 0, 0);
        write_team_count(8'd0);
        random_phase(200, 300, 127);
        for (int i = 0; i < 300; i++) send_item(REQ_ENQUEUE, 10'(400 + (i % 40)), 0);
        for (int i = 0; i < 60; i++) send_item(REQ_DEQUEUE, 0, 0);
        write_team_count(8'd16);
        random_phase(350, 1023, 31);
        write_team_count(8'd5);
        random_phase(350, 1023, 7);
        quiet_phase = 1;
        random_phase(120, 1023, 7);
        for (int i = 0; i < 40; i++) send_item(REQ_DEQUEUE, 0, 0);
        drain();
        $display("Sent %0d items: %0d served, %0d dropped or rejected, across 4 team counts.",
                 sent, sb.served_count, sb.overflow_count);
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("simulation failed");
        $finish;
    end
endmodule
